// ----- rtl/core/first_unique_letter_index_top_assert.svh -----
// ============================================================================
// First unique letter index - assertion macros
// Shared property shapes for the checker of the first unique letter index
// block.
// ============================================================================
`ifndef FIRST_UNIQUE_LETTER_INDEX_TOP_ASSERT_SVH
`define FIRST_UNIQUE_LETTER_INDEX_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define FULI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fuli assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FULI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fuli assertion failed");

`endif

// ----- rtl/core/fuli_pkg.sv -----
// ============================================================================
// First unique letter index - package
// Constants, item types and state encoding shared by the block's modules.
// ============================================================================
`timescale 1ns / 1ps

package fuli_pkg;

    // Sizing
    localparam int MAX_LENGTH    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int LETTER_W      = 5;
    localparam int POS_W         = 10;
    localparam int CNT_W         = 2;
    localparam int QUEUE_DEPTH   = 2;

    // Position counter must hold MAX_LENGTH itself and feed the 10-bit field
    localparam int NPOS_RAW_W = $clog2(MAX_LENGTH + 1);
    localparam int NPOS_W     = (NPOS_RAW_W > POS_W) ? NPOS_RAW_W : POS_W;
    localparam int IDX_W      = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int QPTR_W     = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Saturating occurrence count codes
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONCE = 2'd1;
    localparam logic [CNT_W-1:0] CNT_MANY = 2'd2;

    // Input item
    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                final_letter;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             overflow;
    } t_out_item;

    // Classified item passed from front to back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             in_alpha;
        logic             final_letter;
    } t_cmd;

    // Back end sequencer
    typedef enum logic [1:0] {
        S_RUN,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_back_state;

endpackage

// ----- rtl/core/first_unique_letter_index_top.sv -----
// ============================================================================
// First unique letter index - top level
// Reports the position of the first letter that occurs exactly once in a
// string of letters delivered one per item.
// ============================================================================
//
//   channel   direction  signals                       carries
//   input     in         i_valid, o_stall, i_item      one letter, last mark
//   output    out        o_valid, i_stall, o_item      found, position, overflow
//
// Letters are taken one per cycle while o_stall is low; the front queue holds
// two items. After a final letter the back end scans the alphabet through the
// registered first-seen memory, drains the read stage and emits the result
// before the next string's letters are processed; the queue takes up to two
// more items meanwhile and then stalls the input.
// Reset is synchronous, active low; it clears all counts and the queue.
// A stalled result stays in the output register while the back end waits.
// ============================================================================
`timescale 1ns / 1ps

module first_unique_letter_index_top import fuli_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    // Accept and classify
    fuli_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_cmd     (q_cmd),
        .i_q_pop   (q_pop)
    );

    // Count, scan, report
    fuli_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_item    (o_item)
    );

endmodule

// ----- rtl/core/fuli_front.sv -----
// ============================================================================
// First unique letter index - front end
// Accepts input items, classifies the letter and holds them in a short queue
// for the back end.
// ============================================================================
`timescale 1ns / 1ps

module fuli_front import fuli_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_q_valid,
    output t_cmd     o_cmd,
    input  logic     i_q_pop
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    t_cmd              w_cmd;
    logic              w_push;
    logic              w_pop;

    // Classify: letters beyond the alphabet still take a position
    always_comb begin
        w_cmd.idx          = IDX_W'(i_item.letter);
        w_cmd.in_alpha     = (32'(i_item.letter) < ALPHABET_SIZE);
        w_cmd.final_letter = i_item.final_letter;
    end

    assign o_stall   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_cmd     = r_q[r_rd];

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

// ----- rtl/core/fuli_back.sv -----
// ============================================================================
// First unique letter index - back end
// Updates per-letter counts and first positions, scans the alphabet on the
// final letter and holds the result in the output register.
// ============================================================================
`timescale 1ns / 1ps

module fuli_back import fuli_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_cmd,
    output logic      o_q_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [CNT_W-1:0]  r_cnt  [ALPHABET_SIZE];
    logic [NPOS_W-1:0] r_seen [ALPHABET_SIZE];
    logic [NPOS_W-1:0] r_next_pos;
    logic              r_too_long;
    logic [IDX_W-1:0]  r_scan_k;
    logic              r_rd_v;
    logic              r_rd_one;
    logic [NPOS_W-1:0] r_rd_seen;
    logic              r_found;
    logic [NPOS_W-1:0] r_best;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_pop;
    logic              w_at_limit;
    logic [CNT_W-1:0]  w_cur_cnt;
    logic              w_upd;
    logic              w_out_free;
    logic              w_scan_last;
    logic              w_emit;
    logic              w_hit;
    logic              w_found_eff;

    assign w_pop       = (r_state == S_RUN) && i_q_valid;
    assign w_at_limit  = (r_next_pos >= NPOS_W'(MAX_LENGTH));
    assign w_cur_cnt   = r_cnt[i_cmd.idx];
    assign w_upd       = w_pop && !w_at_limit && i_cmd.in_alpha;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_scan_last = (r_scan_k == IDX_W'(ALPHABET_SIZE - 1));
    assign w_emit      = (r_state == S_EMIT) && w_out_free;
    assign w_hit       = r_rd_v && r_rd_one && (!r_found || (r_rd_seen < r_best));
    assign w_found_eff = r_found && !r_too_long;

    assign o_q_pop = w_pop;
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    // Sequencer: run letters, scan alphabet, drain read stage, emit result
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (w_pop && i_cmd.final_letter) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // String state: counts, position counter, overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ALPHABET_SIZE; k++) begin
                r_cnt[k] <= CNT_NONE;
            end
            r_next_pos <= '0;
            r_too_long <= 1'b0;
        end else if (w_emit) begin
            for (int k = 0; k < ALPHABET_SIZE; k++) begin
                r_cnt[k] <= CNT_NONE;
            end
            r_next_pos <= '0;
            r_too_long <= 1'b0;
        end else if (w_pop) begin
            if (w_at_limit) begin
                r_too_long <= 1'b1;
            end else begin
                r_next_pos <= r_next_pos + 1'b1;
            end
            if (w_upd && (w_cur_cnt != CNT_MANY)) begin
                r_cnt[i_cmd.idx] <= w_cur_cnt + 1'b1;
            end
        end
    end

    // First-seen position memory, with registered scan read
    always_ff @(posedge i_clk) begin
        if (w_upd && (w_cur_cnt == CNT_NONE)) begin
            r_seen[i_cmd.idx] <= r_next_pos;
        end
        r_rd_seen <= r_seen[r_scan_k];
        r_rd_one  <= (r_cnt[r_scan_k] == CNT_ONCE);
    end

    // Scan index and running minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_k <= '0;
            r_rd_v   <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_rd_v <= (r_state == S_SCAN);
            if (r_state == S_SCAN) begin
                r_scan_k <= r_scan_k + 1'b1;
            end else begin
                r_scan_k <= '0;
            end
            if (w_pop && i_cmd.final_letter) begin
                r_found <= 1'b0;
            end else if (w_hit) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_best <= r_rd_seen;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item.found    <= w_found_eff;
            r_out_item.position <= w_found_eff ? r_best[POS_W-1:0] : '0;
            r_out_item.overflow <= r_too_long;
        end
    end

endmodule

// ----- rtl/core/fuli_checker.sv -----
// ============================================================================
// First unique letter index - port checker
// Watches the top level's ports and flags results that cannot be right.
// ============================================================================
`timescale 1ns / 1ps

`include "first_unique_letter_index_top_assert.svh"

module fuli_checker import fuli_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    // A stalled result holds its value
    `FULI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_item))

    // Not found means position zero
    `FULI_ASSERT_IMP(a_pos_zero, i_clk, i_rst_n, o_valid && !o_item.found, o_item.position == '0)

    // An overlong string is never reported as found
    `FULI_ASSERT_IMP(a_ovf_nf, i_clk, i_rst_n, o_valid && o_item.overflow, !o_item.found)

    // No result right after reset
    `FULI_ASSERT_NXT(a_rst_clr, i_clk, 1'b1, !i_rst_n, !o_valid)

endmodule

bind first_unique_letter_index_top fuli_checker u_fuli_checker (.*);
